// File: design/doas_pkg.sv
// ----------------------------------------------------------------------------
// doas_pkg: shared types and constants for the obstacle-avoid drive sequencer
// Packet and result layouts, mode and direction codes, register map, reset
// values and the constant reciprocals used for the steering and duty scaling.
// ----------------------------------------------------------------------------
package doas_pkg;

  // Full-scale steering sample
  localparam int unsigned STEER_MAX = 4095;

  localparam int unsigned SERVO_LO   = 500;
  localparam int unsigned SERVO_HI   = 2400;
  localparam int unsigned SERVO_SPAN = 1900;
  localparam int unsigned SPEED_MAX  = 100;
  localparam int unsigned DUTY_MAX   = 255;

  // steer * SERVO_SPAN / STEER_MAX as one multiply by a rounded-up reciprocal.
  // The shift covers the product width plus the divisor width, so the
  // quotient is exact for every 12-bit sample.
  localparam int unsigned STEER_PROD_W = $clog2(4095 * SERVO_SPAN + 1);
  localparam int unsigned STEER_DIV_SH = STEER_PROD_W + $clog2(STEER_MAX);
  localparam longint unsigned STEER_RECIP =
    ((64'd1 << STEER_DIV_SH) + STEER_MAX - 1) / STEER_MAX;
  localparam longint unsigned STEER_SCALE = STEER_RECIP * SERVO_SPAN;
  localparam int unsigned STEER_MUL_W = 2 * STEER_PROD_W + 2;
  localparam int unsigned STEER_Q_W   = 16;

  // pct * DUTY_MAX / SPEED_MAX, same scheme
  localparam int unsigned DUTY_PROD_W = $clog2(SPEED_MAX * DUTY_MAX + 1);
  localparam int unsigned DUTY_DIV_SH = DUTY_PROD_W + $clog2(SPEED_MAX);
  localparam longint unsigned DUTY_RECIP =
    ((64'd1 << DUTY_DIV_SH) + SPEED_MAX - 1) / SPEED_MAX;
  localparam longint unsigned DUTY_SCALE = DUTY_RECIP * DUTY_MAX;
  localparam int unsigned DUTY_MUL_W = 32;

  // Register map, word index = paddr[4:2]
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_TIME    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SWERVE_TIME  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESTORE_TIME = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_STEP   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AVOID_SPEED  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_AVOID_LIMIT  = 3'd7;

  // Reset values
  localparam logic [15:0] WAIT_TIME_RST    = 16'd5000;
  localparam logic [15:0] SWERVE_TIME_RST  = 16'd4000;
  localparam logic [15:0] RESTORE_TIME_RST = 16'd1500;
  localparam logic [6:0]  SPEED_STEP_RST   = 7'd10;
  localparam logic [6:0]  AVOID_SPEED_RST  = 7'd50;
  localparam logic [10:0] LEFT_OFFSET_RST  = 11'd250;
  localparam logic [10:0] RIGHT_OFFSET_RST = 11'd250;
  localparam logic [10:0] AVOID_LIMIT_RST  = 11'd300;
  localparam logic [6:0]  USER_SPEED_RST   = 7'd50;
  localparam logic [11:0] LAST_STEER_RST   = 12'd1450;

  // Motor direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // Mode codes as reported in the result
  localparam logic [2:0] MODE_CODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_CODE_WAIT    = 3'd1;
  localparam logic [2:0] MODE_CODE_LEFT    = 3'd2;
  localparam logic [2:0] MODE_CODE_RIGHT   = 3'd3;
  localparam logic [2:0] MODE_CODE_RESTORE = 3'd4;

  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_WAIT    = 5'b00010,
    MODE_LEFT    = 5'b00100,
    MODE_RIGHT   = 5'b01000,
    MODE_RESTORE = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [11:0] steer_raw;
    logic        fwd_btn;
    logic        back_btn;
    logic        faster_btn;
    logic        slower_btn;
    logic        obstacle_near;
    logic [31:0] now_ms;
  } rc_item_t;

  typedef struct packed {
    logic [11:0] servo_pulse_us;
    logic        servo_update;
    logic [7:0]  cw_duty;
    logic [7:0]  ccw_duty;
    logic [2:0]  mode_now;
    logic [6:0]  speed_now;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_NORMAL:  code = MODE_CODE_NORMAL;
      MODE_WAIT:    code = MODE_CODE_WAIT;
      MODE_LEFT:    code = MODE_CODE_LEFT;
      MODE_RIGHT:   code = MODE_CODE_RIGHT;
      MODE_RESTORE: code = MODE_CODE_RESTORE;
      default:      code = MODE_CODE_NORMAL;
    endcase
    return code;
  endfunction

  // Clamp a small signed value into the servo range
  function automatic logic [11:0] servo_clamp(input logic signed [13:0] v);
    logic [11:0] r;
    if (v < 14'sd500) begin
      r = 12'(SERVO_LO);
    end else if (v > 14'sd2400) begin
      r = 12'(SERVO_HI);
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

// File: design/drive_obstacle_avoid_sequencer.sv
// ----------------------------------------------------------------------------
// drive_obstacle_avoid_sequencer: remote-control drive and obstacle avoidance
// Maps each control packet to a servo pulse and motor duties, and runs the
// stop / swerve left / swerve right / restore sequence on a lasting obstacle.
// ----------------------------------------------------------------------------
// One packet in, one result out, one packet per clock while in_stall is low. Each
// accepted packet goes through a single level of logic (one reciprocal multiply for
// the steering, one for the duty, one 32-bit elapsed-time compare) into the result
// register, so the result appears on out_valid the cycle after acceptance unless
// out_stall holds the result register. A one-entry skid register behind the result
// register keeps the input side open for one more packet while out_stall is high;
// in_stall rises only when both are full. Configuration registers sit on the APB
// port at word addresses 0..7 and take effect from the next accepted packet.
module drive_obstacle_avoid_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  doas_pkg::rc_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output doas_pkg::result_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [doas_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // Configuration
  logic [15:0] wait_time_ms;
  logic [15:0] swerve_time_ms;
  logic [15:0] restore_time_ms;
  logic [6:0]  speed_step;
  logic [6:0]  avoid_speed;
  logic [10:0] left_offset_us;
  logic [10:0] right_offset_us;
  logic [10:0] avoid_limit_us;

  logic [doas_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_write;

  // Sequencer state
  doas_pkg::mode_t mode, mode_next;
  logic [6:0]  user_speed, user_speed_next;
  logic [11:0] last_steer_us, last_steer_us_next;
  logic [11:0] saved_steer_us, saved_steer_us_next;
  logic [1:0]  saved_direction, saved_direction_next;
  logic        prev_faster, prev_slower;
  logic [31:0] obstacle_since_ms, obstacle_since_ms_next;
  logic [31:0] phase_since_ms, phase_since_ms_next;

  // Output register and skid stage
  logic              skid_full;
  doas_pkg::result_t skid_data;
  doas_pkg::result_t res;
  logic              accept;
  logic              out_take;

  // Datapath
  logic        faster_edge, slower_edge;
  logic [7:0]  speed_sum;
  logic [6:0]  speed_inc, speed_new;
  logic [1:0]  dir;
  logic [doas_pkg::STEER_MUL_W-1:0] steer_prod, steer_shift;
  logic [doas_pkg::STEER_Q_W:0]     steer_sum;
  logic [11:0] steer_pulse;
  logic signed [13:0] last_s, left_raw, left_lo, left_hi, left_bound;
  logic signed [13:0] right_raw;
  logic [11:0] left_pulse, right_pulse;
  logic [31:0] since_ms, elapsed_ms;
  logic [15:0] limit_ms;
  logic        time_up;
  logic [6:0]  pct, pct_sat;
  logic [1:0]  dir_sel;
  logic [doas_pkg::DUTY_MUL_W-1:0] duty_prod;
  logic [7:0]  duty, cw_val, ccw_val;

  // ---------------------------------------------------------------- APB
  assign pready    = 1'b1;
  assign reg_idx   = paddr[doas_pkg::PADDR_W-1:2];
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_time_ms    <= doas_pkg::WAIT_TIME_RST;
      swerve_time_ms  <= doas_pkg::SWERVE_TIME_RST;
      restore_time_ms <= doas_pkg::RESTORE_TIME_RST;
      speed_step      <= doas_pkg::SPEED_STEP_RST;
      avoid_speed     <= doas_pkg::AVOID_SPEED_RST;
      left_offset_us  <= doas_pkg::LEFT_OFFSET_RST;
      right_offset_us <= doas_pkg::RIGHT_OFFSET_RST;
      avoid_limit_us  <= doas_pkg::AVOID_LIMIT_RST;
    end else if (reg_write) begin
      unique case (reg_idx)
        doas_pkg::REG_WAIT_TIME:    wait_time_ms    <= pwdata[15:0];
        doas_pkg::REG_SWERVE_TIME:  swerve_time_ms  <= pwdata[15:0];
        doas_pkg::REG_RESTORE_TIME: restore_time_ms <= pwdata[15:0];
        doas_pkg::REG_SPEED_STEP:   speed_step      <= pwdata[6:0];
        doas_pkg::REG_AVOID_SPEED:  avoid_speed     <= pwdata[6:0];
        doas_pkg::REG_LEFT_OFFSET:  left_offset_us  <= pwdata[10:0];
        doas_pkg::REG_RIGHT_OFFSET: right_offset_us <= pwdata[10:0];
        doas_pkg::REG_AVOID_LIMIT:  avoid_limit_us  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      doas_pkg::REG_WAIT_TIME:    prdata = {16'd0, wait_time_ms};
      doas_pkg::REG_SWERVE_TIME:  prdata = {16'd0, swerve_time_ms};
      doas_pkg::REG_RESTORE_TIME: prdata = {16'd0, restore_time_ms};
      doas_pkg::REG_SPEED_STEP:   prdata = {25'd0, speed_step};
      doas_pkg::REG_AVOID_SPEED:  prdata = {25'd0, avoid_speed};
      doas_pkg::REG_LEFT_OFFSET:  prdata = {21'd0, left_offset_us};
      doas_pkg::REG_RIGHT_OFFSET: prdata = {21'd0, right_offset_us};
      doas_pkg::REG_AVOID_LIMIT:  prdata = {21'd0, avoid_limit_us};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- handshake
  assign in_stall = skid_full;
  assign accept   = in_valid & ~skid_full;
  assign out_take = out_valid & ~out_stall;

  // ------------------------------------------------------------ speed
  assign faster_edge = in_data.faster_btn & ~prev_faster;
  assign slower_edge = in_data.slower_btn & ~prev_slower;
  assign speed_sum   = {1'b0, user_speed} + {1'b0, speed_step};
  assign speed_inc   = !faster_edge ? user_speed :
                       (speed_sum > 8'(doas_pkg::SPEED_MAX)) ? 7'(doas_pkg::SPEED_MAX) :
                       speed_sum[6:0];
  assign speed_new   = !slower_edge ? speed_inc :
                       (speed_inc > speed_step) ? speed_inc - speed_step : 7'd0;

  // Both buttons or neither: stopped
  assign dir = (in_data.fwd_btn && !in_data.back_btn) ? doas_pkg::DIR_FWD :
               (!in_data.fwd_btn && in_data.back_btn) ? doas_pkg::DIR_BACK :
               doas_pkg::DIR_STOP;

  // ---------------------------------------------------------- steering
  assign steer_prod  = doas_pkg::STEER_MUL_W'(in_data.steer_raw) *
                       doas_pkg::STEER_MUL_W'(doas_pkg::STEER_SCALE);
  assign steer_shift = steer_prod >> doas_pkg::STEER_DIV_SH;
  assign steer_sum   = {1'b0, steer_shift[doas_pkg::STEER_Q_W-1:0]} +
                       (doas_pkg::STEER_Q_W+1)'(doas_pkg::SERVO_LO);
  assign steer_pulse = (steer_sum > (doas_pkg::STEER_Q_W+1)'(doas_pkg::SERVO_HI)) ?
                       12'(doas_pkg::SERVO_HI) : steer_sum[11:0];

  // Left swerve: offset bounded to +/- limit around the last pulse
  assign last_s     = signed'({2'b00, last_steer_us});
  assign left_raw   = last_s - signed'({3'b000, left_offset_us});
  assign left_lo    = last_s - signed'({3'b000, avoid_limit_us});
  assign left_hi    = last_s + signed'({3'b000, avoid_limit_us});
  assign left_bound = (left_raw < left_lo) ? left_lo :
                      (left_raw > left_hi) ? left_hi : left_raw;
  assign left_pulse = doas_pkg::servo_clamp(left_bound);

  assign right_raw   = signed'({2'b00, saved_steer_us}) + signed'({3'b000, right_offset_us});
  assign right_pulse = doas_pkg::servo_clamp(right_raw);

  // -------------------------------------------------------- phase timer
  assign since_ms   = (mode == doas_pkg::MODE_WAIT) ? obstacle_since_ms : phase_since_ms;
  assign elapsed_ms = in_data.now_ms - since_ms;

  always_comb begin
    unique case (mode)
      doas_pkg::MODE_WAIT:    limit_ms = wait_time_ms;
      doas_pkg::MODE_RESTORE: limit_ms = restore_time_ms;
      default:                limit_ms = swerve_time_ms;
    endcase
  end

  assign time_up = elapsed_ms > {16'd0, limit_ms};

  // -------------------------------------------------------------- motor
  assign pct     = (mode == doas_pkg::MODE_NORMAL) ? speed_new : avoid_speed;
  assign pct_sat = (pct > 7'(doas_pkg::SPEED_MAX)) ? 7'(doas_pkg::SPEED_MAX) : pct;
  assign dir_sel = (mode == doas_pkg::MODE_NORMAL) ? dir : saved_direction;
  assign duty_prod = doas_pkg::DUTY_MUL_W'(pct_sat) *
                     doas_pkg::DUTY_MUL_W'(doas_pkg::DUTY_SCALE);
  assign duty    = duty_prod[doas_pkg::DUTY_DIV_SH +: 8];
  assign cw_val  = (dir_sel == doas_pkg::DIR_FWD)  ? duty : 8'd0;
  assign ccw_val = (dir_sel == doas_pkg::DIR_BACK) ? duty : 8'd0;

  // ---------------------------------------------------------- sequencer
  always_comb begin
    mode_next              = mode;
    user_speed_next        = user_speed;
    last_steer_us_next     = last_steer_us;
    saved_steer_us_next    = saved_steer_us;
    saved_direction_next   = saved_direction;
    obstacle_since_ms_next = obstacle_since_ms;
    phase_since_ms_next    = phase_since_ms;
    res                    = '0;

    unique case (mode)
      doas_pkg::MODE_NORMAL: begin
        user_speed_next    = speed_new;
        last_steer_us_next = steer_pulse;
        res.servo_pulse_us = steer_pulse;
        res.servo_update   = 1'b1;
        if (in_data.obstacle_near) begin
          obstacle_since_ms_next = in_data.now_ms;
          mode_next              = doas_pkg::MODE_WAIT;
        end else begin
          res.cw_duty  = cw_val;
          res.ccw_duty = ccw_val;
        end
      end
      doas_pkg::MODE_WAIT: begin
        if (!in_data.obstacle_near) begin
          mode_next = doas_pkg::MODE_NORMAL;
        end else if (time_up) begin
          res.servo_pulse_us   = left_pulse;
          res.servo_update     = 1'b1;
          saved_steer_us_next  = last_steer_us;
          saved_direction_next = dir;
          phase_since_ms_next  = in_data.now_ms;
          mode_next            = doas_pkg::MODE_LEFT;
        end
      end
      doas_pkg::MODE_LEFT: begin
        res.cw_duty  = cw_val;
        res.ccw_duty = ccw_val;
        if (time_up) begin
          res.servo_pulse_us  = right_pulse;
          res.servo_update    = 1'b1;
          phase_since_ms_next = in_data.now_ms;
          mode_next           = doas_pkg::MODE_RIGHT;
        end
      end
      doas_pkg::MODE_RIGHT: begin
        res.cw_duty  = cw_val;
        res.ccw_duty = ccw_val;
        if (time_up) begin
          // back to the saved pulse, motor stopped
          res.servo_pulse_us  = saved_steer_us;
          res.servo_update    = 1'b1;
          res.cw_duty         = 8'd0;
          res.ccw_duty        = 8'd0;
          phase_since_ms_next = in_data.now_ms;
          mode_next           = doas_pkg::MODE_RESTORE;
        end
      end
      doas_pkg::MODE_RESTORE: begin
        if (time_up) begin
          mode_next = doas_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_next = doas_pkg::MODE_NORMAL;
      end
    endcase

    res.mode_now  = doas_pkg::mode_code(mode_next);
    res.speed_now = user_speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= doas_pkg::MODE_NORMAL;
      user_speed        <= doas_pkg::USER_SPEED_RST;
      last_steer_us     <= doas_pkg::LAST_STEER_RST;
      saved_steer_us    <= '0;
      saved_direction   <= doas_pkg::DIR_STOP;
      prev_faster       <= 1'b0;
      prev_slower       <= 1'b0;
      obstacle_since_ms <= '0;
      phase_since_ms    <= '0;
    end else if (accept) begin
      mode              <= mode_next;
      user_speed        <= user_speed_next;
      last_steer_us     <= last_steer_us_next;
      saved_steer_us    <= saved_steer_us_next;
      saved_direction   <= saved_direction_next;
      prev_faster       <= in_data.faster_btn;
      prev_slower       <= in_data.slower_btn;
      obstacle_since_ms <= obstacle_since_ms_next;
      phase_since_ms    <= phase_since_ms_next;
    end
  end

  // ------------------------------------------------ result and skid regs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_take) begin
      // drain the skid entry first; no item is accepted while it is full
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_full) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  // ---------------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held while result register is empty");

  a_no_pulse_without_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.servo_update |-> out_data.servo_pulse_us == 12'd0)
    else $error("servo pulse nonzero without servo update");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cw_duty == 8'd0 || out_data.ccw_duty == 8'd0))
    else $error("both motor duties driven");

  a_speed_held_outside_normal: assert property (@(posedge clk) disable iff (rst)
    accept && mode != doas_pkg::MODE_NORMAL |=> user_speed == $past(user_speed))
    else $error("user speed changed outside normal mode");

endmodule

// File: bench/tb_drive_obstacle_avoid_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drive_obstacle_avoid_sequencer: self-checking bench for the drive sequencer
// Sends remote-control packets through the valid/stall input, programs the
// timing and steering registers over APB between phases, and checks every
// result against a behavioral copy of the drive and avoidance logic, or against a
// pinned expected result. A short scripted run covers reset, extremes, the speed
// buttons, a complete avoidance manoeuvre and a wait across a timer wrap. Random
// runs then push obstacle episodes through every mode under several register
// settings, with random idle and stall bursts and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_drive_obstacle_avoid_sequencer;

  localparam int QUIET_LIMIT = 1000;
  localparam int BACKLOG_AT = 500;
  localparam int BACKLOG_CYCLES = 40;

  // Button masks for the scripted rows, in packet bit order
  localparam logic [4:0] BTN_FWD    = 5'b10000;
  localparam logic [4:0] BTN_BACK   = 5'b01000;
  localparam logic [4:0] BTN_FASTER = 5'b00100;
  localparam logic [4:0] BTN_SLOWER = 5'b00010;
  localparam logic [4:0] BTN_OBST   = 5'b00001;

  typedef struct {
    doas_pkg::rc_item_t pkt;
    bit                 pinned;
    doas_pkg::result_t  want;
  } script_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  doas_pkg::rc_item_t in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  doas_pkg::result_t  out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [doas_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Behavioral copy of the registers and the car state
  logic [15:0] cfg_wait_ms, cfg_swerve_ms, cfg_restore_ms;
  logic [6:0]  cfg_step, cfg_avoid_pct;
  logic [10:0] cfg_left_us, cfg_right_us, cfg_limit_us;
  logic [2:0]  car_mode;
  logic [6:0]  car_speed;
  logic [11:0] car_steer_us, held_steer_us;
  logic [1:0]  held_dir;
  logic        faster_q, slower_q;
  logic [31:0] obst_start_ms, phase_start_ms;

  doas_pkg::result_t pending_results[$];
  script_row_t script[$];
  int          err_count = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  bit          backlog_done = 1'b0;
  bit          gaps_on = 1'b1;
  bit          obst_level = 1'b0;
  logic [31:0] clock_ms = '0;

  drive_obstacle_avoid_sequencer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [11:0] servo_limit(input int v);
    if (v < int'(doas_pkg::SERVO_LO)) return 12'(doas_pkg::SERVO_LO);
    if (v > int'(doas_pkg::SERVO_HI)) return 12'(doas_pkg::SERVO_HI);
    return 12'(v);
  endfunction

  function automatic logic [15:0] motor_duty(input logic [1:0] dir, input logic [6:0] pct);
    int unsigned pct_c;
    logic [7:0]  duty;
    pct_c = (pct > 7'd100) ? 100 : pct;
    duty = 8'(pct_c * 255 / 100);
    case (dir)
      doas_pkg::DIR_FWD:  return {duty, 8'd0};
      doas_pkg::DIR_BACK: return {8'd0, duty};
      default:            return 16'd0;
    endcase
  endfunction

  function automatic void reset_car();
    cfg_wait_ms = doas_pkg::WAIT_TIME_RST;
    cfg_swerve_ms = doas_pkg::SWERVE_TIME_RST;
    cfg_restore_ms = doas_pkg::RESTORE_TIME_RST;
    cfg_step = doas_pkg::SPEED_STEP_RST;
    cfg_avoid_pct = doas_pkg::AVOID_SPEED_RST;
    cfg_left_us = doas_pkg::LEFT_OFFSET_RST;
    cfg_right_us = doas_pkg::RIGHT_OFFSET_RST;
    cfg_limit_us = doas_pkg::AVOID_LIMIT_RST;
    car_mode = doas_pkg::MODE_CODE_NORMAL;
    car_speed = doas_pkg::USER_SPEED_RST;
    car_steer_us = doas_pkg::LAST_STEER_RST;
    held_steer_us = '0;
    held_dir = doas_pkg::DIR_STOP;
    faster_q = 1'b0;
    slower_q = 1'b0;
    obst_start_ms = '0;
    phase_start_ms = '0;
  endfunction

  // One packet through the drive logic; returns the result it produces
  function automatic doas_pkg::result_t predict_drive(input doas_pkg::rc_item_t p);
    doas_pkg::result_t r;
    logic [1:0]  dir;
    int unsigned sum;
    int          last, lim, pulse;
    r = '0;
    if (car_mode == doas_pkg::MODE_CODE_NORMAL) begin
      if (p.faster_btn && !faster_q) begin
        sum = car_speed + cfg_step;
        car_speed = (sum > 100) ? 7'd100 : 7'(sum);
      end
      if (p.slower_btn && !slower_q)
        car_speed = (car_speed > cfg_step) ? car_speed - cfg_step : 7'd0;
      if (car_speed > 7'd100) car_speed = 7'd100;
    end
    faster_q = p.faster_btn;
    slower_q = p.slower_btn;

    if (car_mode == doas_pkg::MODE_CODE_NORMAL) begin
      car_steer_us = servo_limit(int'(p.steer_raw * 1900 / doas_pkg::STEER_MAX) +
                                 int'(doas_pkg::SERVO_LO));
      r.servo_pulse_us = car_steer_us;
      r.servo_update = 1'b1;
    end

    if (p.fwd_btn && !p.back_btn) dir = doas_pkg::DIR_FWD;
    else if (!p.fwd_btn && p.back_btn) dir = doas_pkg::DIR_BACK;
    else dir = doas_pkg::DIR_STOP;

    case (car_mode)
      doas_pkg::MODE_CODE_NORMAL: begin
        if (p.obstacle_near) begin
          obst_start_ms = p.now_ms;
          car_mode = doas_pkg::MODE_CODE_WAIT;
        end else begin
          {r.cw_duty, r.ccw_duty} = motor_duty(dir, car_speed);
        end
      end
      doas_pkg::MODE_CODE_WAIT: begin
        if (!p.obstacle_near) begin
          car_mode = doas_pkg::MODE_CODE_NORMAL;
        end else if (32'(p.now_ms - obst_start_ms) > {16'd0, cfg_wait_ms}) begin
          last = int'(car_steer_us);
          lim = int'(cfg_limit_us);
          // bound the left deviation around the saved pulse, then to the servo range
          pulse = last - int'(cfg_left_us);
          if (pulse < last - lim) pulse = last - lim;
          else if (pulse > last + lim) pulse = last + lim;
          held_steer_us = car_steer_us;
          held_dir = dir;
          r.servo_pulse_us = servo_limit(pulse);
          r.servo_update = 1'b1;
          phase_start_ms = p.now_ms;
          car_mode = doas_pkg::MODE_CODE_LEFT;
        end
      end
      doas_pkg::MODE_CODE_LEFT: begin
        {r.cw_duty, r.ccw_duty} = motor_duty(held_dir, cfg_avoid_pct);
        if (32'(p.now_ms - phase_start_ms) > {16'd0, cfg_swerve_ms}) begin
          r.servo_pulse_us = servo_limit(int'(held_steer_us) + int'(cfg_right_us));
          r.servo_update = 1'b1;
          phase_start_ms = p.now_ms;
          car_mode = doas_pkg::MODE_CODE_RIGHT;
        end
      end
      doas_pkg::MODE_CODE_RIGHT: begin
        {r.cw_duty, r.ccw_duty} = motor_duty(held_dir, cfg_avoid_pct);
        if (32'(p.now_ms - phase_start_ms) > {16'd0, cfg_swerve_ms}) begin
          // back to the saved pulse, motor stopped
          r.servo_pulse_us = held_steer_us;
          r.servo_update = 1'b1;
          r.cw_duty = 8'd0;
          r.ccw_duty = 8'd0;
          phase_start_ms = p.now_ms;
          car_mode = doas_pkg::MODE_CODE_RESTORE;
        end
      end
      doas_pkg::MODE_CODE_RESTORE: begin
        if (32'(p.now_ms - phase_start_ms) > {16'd0, cfg_restore_ms})
          car_mode = doas_pkg::MODE_CODE_NORMAL;
      end
      default: car_mode = doas_pkg::MODE_CODE_NORMAL;
    endcase
    r.mode_now = car_mode;
    r.speed_now = car_speed;
    return r;
  endfunction

  // Random packet, shaped to walk obstacle episodes through every mode
  function automatic doas_pkg::rc_item_t roll_packet();
    doas_pkg::rc_item_t p;
    int unsigned pick;
    logic [31:0] base;
    logic [15:0] limit;
    bit          timed;
    pick = $urandom_range(0, 9);
    p.steer_raw = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom_range(0, 4095));
    p.fwd_btn = 1'($urandom_range(0, 1));
    p.back_btn = 1'($urandom_range(0, 1));
    p.faster_btn = 1'($urandom_range(0, 1));
    p.slower_btn = 1'($urandom_range(0, 1));
    // keep the obstacle up for long stretches, drop it now and then
    if (!obst_level && $urandom_range(0, 9) == 0) obst_level = 1'b1;
    else if (obst_level && $urandom_range(0, 39) == 0) obst_level = 1'b0;
    p.obstacle_near = ($urandom_range(0, 19) == 0) ? ~obst_level : obst_level;

    timed = 1'b1;
    case (car_mode)
      doas_pkg::MODE_CODE_WAIT: begin
        base = obst_start_ms; limit = cfg_wait_ms;
      end
      doas_pkg::MODE_CODE_LEFT, doas_pkg::MODE_CODE_RIGHT: begin
        base = phase_start_ms; limit = cfg_swerve_ms;
      end
      doas_pkg::MODE_CODE_RESTORE: begin
        base = phase_start_ms; limit = cfg_restore_ms;
      end
      default: begin base = '0; limit = '0; timed = 1'b0; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) clock_ms = $urandom();
    else if (timed && pick < 45) clock_ms = base + limit + $urandom_range(0, 2) - 1;
    else clock_ms = clock_ms + $urandom_range(0, 40);
    p.now_ms = clock_ms;
    return p;
  endfunction

  function automatic void add_row(input logic [11:0] steer, input logic [4:0] btns,
                                  input logic [31:0] now);
    script_row_t row;
    row.pkt = {steer, btns, now};
    row.pinned = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void pin_result(input doas_pkg::result_t want);
    script[$].pinned = 1'b1;
    script[$].want = want;
  endfunction

  task automatic check_result(input doas_pkg::result_t got, input doas_pkg::result_t want);
    if (got.servo_pulse_us !== want.servo_pulse_us) begin
      $error("servo_pulse_us: expected %0d, got %0d", want.servo_pulse_us, got.servo_pulse_us);
      err_count++;
    end
    if (got.servo_update !== want.servo_update) begin
      $error("servo_update: expected %0d, got %0d", want.servo_update, got.servo_update);
      err_count++;
    end
    if (got.cw_duty !== want.cw_duty) begin
      $error("cw_duty: expected %0d, got %0d", want.cw_duty, got.cw_duty);
      err_count++;
    end
    if (got.ccw_duty !== want.ccw_duty) begin
      $error("ccw_duty: expected %0d, got %0d", want.ccw_duty, got.ccw_duty);
      err_count++;
    end
    if (got.mode_now !== want.mode_now) begin
      $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
      err_count++;
    end
    if (got.speed_now !== want.speed_now) begin
      $error("speed_now: expected %0d, got %0d", want.speed_now, got.speed_now);
      err_count++;
    end
  endtask

  // Offer one packet, hold it until taken, then record what it must produce
  task automatic push_packet(input doas_pkg::rc_item_t p, input bit pinned,
                             input doas_pkg::result_t want);
    doas_pkg::result_t guess;
    int      gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = predict_drive(p);
    pending_results.push_back(pinned ? want : guess);
  endtask

  task automatic run_random(input int count, input bit tail);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) gaps_on = !tail && ($urandom_range(0, 2) != 0);
      push_packet(roll_packet(), 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [doas_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= doas_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      doas_pkg::REG_WAIT_TIME:    cfg_wait_ms = value[15:0];
      doas_pkg::REG_SWERVE_TIME:  cfg_swerve_ms = value[15:0];
      doas_pkg::REG_RESTORE_TIME: cfg_restore_ms = value[15:0];
      doas_pkg::REG_SPEED_STEP:   cfg_step = value[6:0];
      doas_pkg::REG_AVOID_SPEED:  cfg_avoid_pct = value[6:0];
      doas_pkg::REG_LEFT_OFFSET:  cfg_left_us = value[10:0];
      doas_pkg::REG_RIGHT_OFFSET: cfg_right_us = value[10:0];
      doas_pkg::REG_AVOID_LIMIT:  cfg_limit_us = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int wait_ms, input int swerve_ms, input int restore_ms,
                            input int step, input int avoid_pct, input int left_us,
                            input int right_us, input int limit_us);
    apb_write(doas_pkg::REG_WAIT_TIME, wait_ms);
    apb_write(doas_pkg::REG_SWERVE_TIME, swerve_ms);
    apb_write(doas_pkg::REG_RESTORE_TIME, restore_ms);
    apb_write(doas_pkg::REG_SPEED_STEP, step);
    apb_write(doas_pkg::REG_AVOID_SPEED, avoid_pct);
    apb_write(doas_pkg::REG_LEFT_OFFSET, left_us);
    apb_write(doas_pkg::REG_RIGHT_OFFSET, right_us);
    apb_write(doas_pkg::REG_AVOID_LIMIT, limit_us);
  endtask

  // Result side: check each item, stall in bursts, and hold off once for long
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result arrived with no packet pending");
          err_count++;
        end else begin
          check_result(out_data, pending_results.pop_front());
        end
      end
      if (results_seen == BACKLOG_AT && !backlog_done) begin
        backlog_done = 1'b1;
        hold_left = BACKLOG_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_car();
    add_row(12'd0, 5'b00000, 32'd0);
    pin_result('{servo_pulse_us: 12'd500, servo_update: 1'b1, cw_duty: 8'd0, ccw_duty: 8'd0,
                 mode_now: doas_pkg::MODE_CODE_NORMAL, speed_now: 7'd50});
    add_row(12'd4095, BTN_FWD, 32'd10);
    pin_result('{servo_pulse_us: 12'd2400, servo_update: 1'b1, cw_duty: 8'd127,
                 ccw_duty: 8'd0, mode_now: doas_pkg::MODE_CODE_NORMAL, speed_now: 7'd50});
    add_row(12'd2048, BTN_BACK, 32'd20);
    add_row(12'd1234, BTN_FWD | BTN_BACK, 32'd30);
    add_row(12'd3000, BTN_FWD | BTN_FASTER, 32'd40);
    add_row(12'd3000, BTN_FWD | BTN_FASTER, 32'd50);
    add_row(12'd3000, BTN_BACK | BTN_SLOWER, 32'd60);
    add_row(12'd3000, BTN_BACK, 32'd70);
    add_row(12'd3000, BTN_FWD | BTN_FASTER | BTN_SLOWER, 32'd80);
    // obstacle episode at the reset timings
    add_row(12'd1000, BTN_FWD | BTN_OBST, 32'd100);
    add_row(12'd1000, BTN_FWD | BTN_OBST, 32'd5100);
    add_row(12'd1000, BTN_FWD | BTN_OBST, 32'd5101);
    add_row(12'd4095, 5'b00000, 32'd9101);
    add_row(12'd4095, BTN_BACK, 32'd9102);
    add_row(12'd0, 5'b00000, 32'd13102);
    add_row(12'd0, 5'b00000, 32'd13103);
    add_row(12'd0, BTN_OBST | BTN_SLOWER, 32'd14603);
    add_row(12'd2000, BTN_FASTER, 32'd14604);
    // wait across the timer wrap
    add_row(12'd2000, BTN_SLOWER | BTN_OBST, 32'hFFFF_F000);
    add_row(12'd2000, BTN_OBST, 32'h0000_0388);
    add_row(12'd2000, BTN_OBST | BTN_BACK, 32'h0000_0389);
    clock_ms = 32'h0000_0389;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) push_packet(script[i].pkt, script[i].pinned, script[i].want);
    run_random(320, 1'b0);

    drain();
    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(330, 1'b0);

    drain();
    set_config(65535, 65535, 65535, 100, 100, 1900, 1900, 1900);
    run_random(330, 1'b0);

    // widest field values, short phases
    drain();
    set_config(3, 7, 2, 127, 127, 2047, 2047, 2047);
    run_random(330, 1'b0);

    drain();
    set_config($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 2047),
               $urandom_range(0, 2047), $urandom_range(0, 2047));
    run_random(330, 1'b0);

    drain();
    set_config($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200),
               $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 1900),
               $urandom_range(0, 1900), $urandom_range(0, 1900));
    run_random(330, 1'b1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
